// File: rtl/core/hrl_pkg.sv
// Package for the hex record image loader: sizes, character codes, record
// kinds, status codes and the queue item type. Depends on nothing.
package hrl_pkg;

   localparam int IMAGE_DEPTH = 65536;
   localparam int LINE_LIMIT  = 1024;
   localparam int IMG_AW      = $clog2(IMAGE_DEPTH);
   localparam int LP_W        = $clog2(LINE_LIMIT + 1);
   localparam int MAX_DECODED = 256 + 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [16:0] LENGTH_MAX = 17'h1FFFF;

   localparam logic [7:0] KIND_DATA   = 8'h00;
   localparam logic [7:0] KIND_EOF    = 8'h01;
   localparam logic [7:0] KIND_EXTLIN = 8'h04;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef enum logic [2:0] {
      ST_CONTINUE    = 3'd0,
      ST_DONE        = 3'd1,
      ST_BAD_LINE    = 3'd2,
      ST_BAD_SUM     = 3'd3,
      ST_LINE_OVF    = 3'd4,
      ST_IMAGE_OVF   = 3'd5,
      ST_IMAGE_EMPTY = 3'd6
   } status_type;

   typedef struct packed {
      logic        is_read;
      logic        plus;
      logic        line_end;
      logic        colon;
      logic        hex;
      logic [3:0]  nibble;
      logic [15:0] read_address;
   } item_type;

endpackage

// File: rtl/core/hrl_front.sv
// Front end of the hex record image loader: accepts input beats and
// classifies each received character. Depends on hrl_pkg.
module hrl_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,   // func
   input  logic [23:0]       req_tdata,   // byte_in [7:0], read_address [23:8]
   input  logic              q_full,
   output logic              push,
   output hrl_pkg::item_type push_item
);
   import hrl_pkg::*;

   logic [7:0] ch;
   logic       is_digit;
   logic       is_lower;
   logic       is_upper;

   assign ch       = req_tdata[7:0];
   assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
   assign is_lower = (ch >= 8'h61) && (ch <= 8'h66);
   assign is_upper = (ch >= 8'h41) && (ch <= 8'h46);

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_item.is_read      = req_tuser;
      push_item.plus         = (ch == CHAR_PLUS);
      push_item.line_end     = (ch == CHAR_LF) || (ch == CHAR_CR) || (ch == CHAR_NUL);
      push_item.colon        = (ch == CHAR_COLON);
      push_item.hex          = is_digit || is_lower || is_upper;
      push_item.nibble       = is_digit ? ch[3:0] : 4'(ch[3:0] + 4'd9);
      push_item.read_address = req_tdata[23:8];
   end

endmodule

// File: rtl/core/hrl_queue.sv
// Short queue between the front end and the back end of the loader.
// Depends on hrl_pkg for its depth and item type.
module hrl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrl_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output hrl_pkg::item_type head
);
   import hrl_pkg::*;

   localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/hrl_back.sv
// Back end of the loader: record parser state, image memory and the result
// register. Depends on hrl_pkg.
module hrl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  hrl_pkg::item_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata    // status [2:0], image_length [19:3],
                                          // read_data [27:20], zeros above
);
   import hrl_pkg::*;

   logic [7:0] mem [IMAGE_DEPTH];

   logic             header_skip_ff, header_skip_in;
   logic [LP_W-1:0]  line_pos_ff, line_pos_in;
   logic             colon_seen_ff, colon_seen_in;
   logic             nib_phase_ff, nib_phase_in;
   logic [3:0]       high_nib_ff, high_nib_in;
   logic [8:0]       dec_count_ff, dec_count_in;
   logic [7:0]       byte_sum_ff, byte_sum_in;
   logic [7:0]       rec_count_ff, rec_count_in;
   logic [7:0]       rec_kind_ff, rec_kind_in;
   logic [2:0]       pend_err_ff, pend_err_in;
   logic [2:0]       sticky_err_ff, sticky_err_in;
   logic [16:0]      img_off_ff, img_off_in;

   logic             out_valid_ff;
   status_type       out_status_ff;
   logic [16:0]      out_len_ff;
   logic             out_rd_sel_ff;
   logic [7:0]       rd_data_ff;

   status_type       status;
   logic             wr_en;
   logic [17:0]      wr_addr;
   logic [7:0]       wr_val;
   logic [31:0]      wr_addr32;
   logic [31:0]      rd_addr32;
   logic             rd_in_range;
   logic [7:0]       value;
   logic [8:0]       pay_idx;
   logic [17:0]      len_sum;
   logic [16:0]      len_sat;

   assign pop       = q_not_empty && (!out_valid_ff || rsp_tready);
   assign value     = {high_nib_ff, head.nibble};
   assign pay_idx   = 9'(dec_count_ff - 9'd4);
   assign wr_addr   = {1'b0, img_off_ff} + {9'b0, pay_idx};
   assign wr_addr32 = 32'(wr_addr);
   assign rd_addr32 = 32'(head.read_address);
   assign rd_in_range = rd_addr32 < 32'(IMAGE_DEPTH);
   assign len_sum   = {1'b0, img_off_ff} + {10'b0, rec_count_ff};
   assign len_sat   = (len_sum > {1'b0, LENGTH_MAX}) ? LENGTH_MAX : len_sum[16:0];
   assign wr_val    = value;

   always_comb begin
      header_skip_in = header_skip_ff;
      line_pos_in    = line_pos_ff;
      colon_seen_in  = colon_seen_ff;
      nib_phase_in   = nib_phase_ff;
      high_nib_in    = high_nib_ff;
      dec_count_in   = dec_count_ff;
      byte_sum_in    = byte_sum_ff;
      rec_count_in   = rec_count_ff;
      rec_kind_in    = rec_kind_ff;
      pend_err_in    = pend_err_ff;
      sticky_err_in  = sticky_err_ff;
      img_off_in     = img_off_ff;
      status         = ST_CONTINUE;
      wr_en          = 1'b0;

      if (head.is_read) begin
         status = ST_CONTINUE;
      end else if (head.plus) begin
         line_pos_in    = '0;
         colon_seen_in  = 1'b0;
         nib_phase_in   = 1'b0;
         high_nib_in    = '0;
         dec_count_in   = '0;
         byte_sum_in    = '0;
         rec_count_in   = '0;
         rec_kind_in    = '0;
         pend_err_in    = '0;
         img_off_in     = '0;
         sticky_err_in  = '0;
         header_skip_in = 1'b1;
      end else if (header_skip_ff) begin
         if (head.line_end) begin
            header_skip_in = 1'b0;
         end
      end else if (line_pos_ff >= LP_W'(LINE_LIMIT)) begin
         status = ST_LINE_OVF;
      end else begin
         line_pos_in = LP_W'(line_pos_ff + 1'b1);
         if (!head.line_end) begin
            if (sticky_err_ff == '0 && pend_err_ff == '0) begin
               if (!colon_seen_ff) begin
                  if (head.colon) begin
                     colon_seen_in = 1'b1;
                  end
               end else if (dec_count_ff < 9'(MAX_DECODED)) begin
                  if (!head.hex) begin
                     pend_err_in = ST_BAD_LINE;
                  end else if (!nib_phase_ff) begin
                     high_nib_in  = head.nibble;
                     nib_phase_in = 1'b1;
                  end else begin
                     nib_phase_in = 1'b0;
                     byte_sum_in  = 8'(byte_sum_ff + value);
                     if (dec_count_ff == 9'd0) begin
                        rec_count_in = value;
                     end
                     if (dec_count_ff == 9'd3) begin
                        rec_kind_in = value;
                     end
                     if (dec_count_ff >= 9'd4 && rec_kind_ff == KIND_DATA &&
                         pay_idx < {1'b0, rec_count_ff} &&
                         wr_addr32 < 32'(IMAGE_DEPTH)) begin
                        wr_en = 1'b1;
                     end
                     dec_count_in = 9'(dec_count_ff + 1'b1);
                  end
               end
            end
         end else if (sticky_err_ff != '0) begin
            status = status_type'(sticky_err_ff);
         end else begin
            priority if (line_pos_ff == '0) begin
               status = ST_CONTINUE;
            end else if (pend_err_ff != '0 || !colon_seen_ff || nib_phase_ff ||
                         dec_count_ff == '0) begin
               status = ST_BAD_LINE;
            end else if (byte_sum_ff != '0) begin
               status = ST_BAD_SUM;
            end else if (dec_count_ff < 9'd5 ||
                         {1'b0, rec_count_ff} > 9'(dec_count_ff - 9'd5)) begin
               status = ST_BAD_LINE;
            end else begin
               if (rec_kind_ff == KIND_DATA) begin
                  img_off_in = len_sat;
                  status = (32'(len_sat) >= 32'(IMAGE_DEPTH)) ? ST_IMAGE_OVF
                                                               : ST_CONTINUE;
               end else if (rec_kind_ff == KIND_EOF) begin
                  status = (img_off_ff == '0) ? ST_IMAGE_EMPTY : ST_DONE;
               end else if (rec_kind_ff == KIND_EXTLIN) begin
                  img_off_in = '0;
               end
            end
            if (status == ST_BAD_LINE || status == ST_BAD_SUM) begin
               sticky_err_in = status;
            end else begin
               line_pos_in   = '0;
               colon_seen_in = 1'b0;
               nib_phase_in  = 1'b0;
               high_nib_in   = '0;
               dec_count_in  = '0;
               byte_sum_in   = '0;
               rec_count_in  = '0;
               rec_kind_in   = '0;
               pend_err_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= 1'b0;
         line_pos_ff    <= '0;
         colon_seen_ff  <= 1'b0;
         nib_phase_ff   <= 1'b0;
         high_nib_ff    <= '0;
         dec_count_ff   <= '0;
         byte_sum_ff    <= '0;
         rec_count_ff   <= '0;
         rec_kind_ff    <= '0;
         pend_err_ff    <= '0;
         sticky_err_ff  <= '0;
         img_off_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            header_skip_ff <= header_skip_in;
            line_pos_ff    <= line_pos_in;
            colon_seen_ff  <= colon_seen_in;
            nib_phase_ff   <= nib_phase_in;
            high_nib_ff    <= high_nib_in;
            dec_count_ff   <= dec_count_in;
            byte_sum_ff    <= byte_sum_in;
            rec_count_ff   <= rec_count_in;
            rec_kind_ff    <= rec_kind_in;
            pend_err_ff    <= pend_err_in;
            sticky_err_ff  <= sticky_err_in;
            img_off_ff     <= img_off_in;
            out_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_status_ff <= status;
         out_len_ff    <= img_off_in;
         out_rd_sel_ff <= head.is_read && rd_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && wr_en && !head.is_read) begin
         mem[wr_addr32[IMG_AW-1:0]] <= wr_val;
      end
      if (pop && head.is_read) begin
         rd_data_ff <= mem[rd_addr32[IMG_AW-1:0]];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, (out_rd_sel_ff ? rd_data_ff : 8'h00), out_len_ff,
                        out_status_ff};

endmodule

// File: rtl/core/hex_record_image_loader_top.sv
// Top level of the hex record image loader. Depends on hrl_pkg, hrl_front,
// hrl_queue and hrl_back.
// Each input beat is written into a queue slot and then into the result register
// before its result beat can be taken; a stalled response holds it in the queue.
// Throughput: one beat per cycle while the response stream is not stalled, set by
// the parser update and the one write or read per cycle on the image memory port.
// Reset is synchronous and active high; it clears the parser, the queue and the
// result register. The image memory is not cleared and needs no clearing pass.
module hex_record_image_loader_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // func
   input  logic [23:0] req_tdata,   // byte_in [7:0], read_address [23:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status [2:0], image_length [19:3],
                                    // read_data [27:20], zeros above
);
   import hrl_pkg::*;

   logic     q_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     q_not_empty;
   item_type head;

   hrl_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   hrl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (head)
   );

   hrl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// File: sim/hex_record_image_loader_checker.sv
`timescale 1ns / 1ps
// Checker for the hex record image loader: watches the request and response
// streams, predicts every response beat and compares it field by field.
// Depends on hrl_pkg.
module hex_record_image_loader_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,    // func
   input  logic [23:0] req_tdata,    // byte_in [7:0], read_address [23:8]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // status [2:0], image_length [19:3],
                                     // read_data [27:20], zeros above
   output int          error_count,
   output int          pending_count,
   output logic [16:0] written_span
);
   import hrl_pkg::*;

   typedef struct packed {
      logic [7:0]  data;
      logic [16:0] length;
      status_type  status;
   } loader_rsp_type;

   loader_rsp_type awaited_rsp_q[$];
   loader_rsp_type want;
   int             rsp_index;

   logic        hdr_skip;
   logic [10:0] line_pos;
   logic        colon_seen;
   logic        nib_phase;
   logic [3:0]  hi_nib;
   logic [8:0]  n_decoded;
   logic [7:0]  sum_acc;
   logic [7:0]  rec_count;
   logic [7:0]  rec_kind;
   status_type  line_err;
   status_type  sticky_err;
   logic [16:0] img_len;
   logic [7:0]  img_mem [0:IMAGE_DEPTH-1];

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         return {1'b1, c[3:0] + 4'd9};
      end
      return 5'd0;
   endfunction

   task automatic clear_line_state();
      line_pos   = '0;
      colon_seen = 1'b0;
      nib_phase  = 1'b0;
      hi_nib     = '0;
      n_decoded  = '0;
      sum_acc    = '0;
      rec_count  = '0;
      rec_kind   = '0;
      line_err   = ST_CONTINUE;
   endtask

   task automatic decode_char(input logic [7:0] c);
      logic [4:0]  dig;
      logic [7:0]  value;
      logic [8:0]  idx;
      logic [17:0] addr;
      dig = hex_digit(c);
      if (line_err == ST_CONTINUE) begin
         if (!colon_seen) begin
            if (c == CHAR_COLON) colon_seen = 1'b1;
         end else if (n_decoded < MAX_DECODED) begin
            if (!dig[4]) begin
               line_err = ST_BAD_LINE;
            end else if (!nib_phase) begin
               hi_nib    = dig[3:0];
               nib_phase = 1'b1;
            end else begin
               nib_phase = 1'b0;
               value     = {hi_nib, dig[3:0]};
               idx       = n_decoded;
               sum_acc   = sum_acc + value;
               if (idx == 9'd0) rec_count = value;
               if (idx == 9'd3) rec_kind = value;
               if (idx >= 9'd4 && rec_kind == KIND_DATA &&
                   (idx - 9'd4) < {1'b0, rec_count}) begin
                  addr = {1'b0, img_len} + 18'(idx - 9'd4);
                  if (addr < IMAGE_DEPTH) img_mem[addr[15:0]] = value;
               end
               n_decoded = idx + 9'd1;
            end
         end
      end
   endtask

   task automatic finish_line(output status_type st);
      logic [17:0] total;
      logic [7:0]  kind;
      logic [7:0]  count;
      st = ST_CONTINUE;
      if (line_err != ST_CONTINUE || !colon_seen || nib_phase || n_decoded == 9'd0) begin
         st = ST_BAD_LINE;
      end else if (sum_acc != 8'd0) begin
         st = ST_BAD_SUM;
      end else if (n_decoded < 9'd5 || {1'b0, rec_count} > n_decoded - 9'd5) begin
         st = ST_BAD_LINE;
      end
      if (st != ST_CONTINUE) begin
         sticky_err = st;
      end else begin
         kind  = rec_kind;
         count = rec_count;
         clear_line_state();
         if (kind == KIND_DATA) begin
            total = {1'b0, img_len} + 18'(count);
            if (total > LENGTH_MAX) img_len = LENGTH_MAX;
            else img_len = total[16:0];
            if (img_len >= IMAGE_DEPTH) st = ST_IMAGE_OVF;
            // Every address below a committed length holds a written byte.
            if (img_len >= IMAGE_DEPTH) written_span = 17'(IMAGE_DEPTH);
            else if (img_len > written_span) written_span = img_len;
         end else if (kind == KIND_EOF) begin
            if (img_len == '0) st = ST_IMAGE_EMPTY;
            else st = ST_DONE;
         end else if (kind == KIND_EXTLIN) begin
            img_len = '0;
         end
      end
   endtask

   task automatic parse_beat(input logic func, input logic [7:0] ch,
                             input logic [15:0] addr, output loader_rsp_type r);
      logic       is_end;
      logic       was_empty;
      status_type st;
      r.status = ST_CONTINUE;
      r.data   = '0;
      if (func) begin
         r.data = img_mem[addr];
      end else begin
         is_end = (ch == CHAR_LF) || (ch == CHAR_CR) || (ch == CHAR_NUL);
         if (ch == CHAR_PLUS) begin
            clear_line_state();
            img_len    = '0;
            sticky_err = ST_CONTINUE;
            hdr_skip   = 1'b1;
         end else if (hdr_skip) begin
            if (is_end) hdr_skip = 1'b0;
         end else if (line_pos >= LINE_LIMIT) begin
            r.status = ST_LINE_OVF;
         end else begin
            was_empty = (line_pos == '0);
            line_pos  = line_pos + 11'd1;
            if (!is_end) begin
               if (sticky_err == ST_CONTINUE) decode_char(ch);
            end else if (sticky_err != ST_CONTINUE) begin
               r.status = sticky_err;
            end else if (was_empty) begin
               clear_line_state();
            end else begin
               finish_line(st);
               r.status = st;
            end
         end
      end
      r.length = img_len;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] exp_value);
      $display("%0t: response beat %0d, %s: got 0x%0h, expected 0x%0h",
               $time, rsp_index, field, got, exp_value);
      error_count = error_count + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line_state();
         hdr_skip     = 1'b0;
         sticky_err   = ST_CONTINUE;
         img_len      = '0;
         written_span = '0;
         rsp_index    = 0;
         awaited_rsp_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsp_q.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_tdata, '0);
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_tdata[2:0] !== want.status)
                  report_mismatch("status", 32'(rsp_tdata[2:0]), 32'(want.status));
               if (rsp_tdata[19:3] !== want.length)
                  report_mismatch("image_length", 32'(rsp_tdata[19:3]), 32'(want.length));
               if (rsp_tdata[27:20] !== want.data)
                  report_mismatch("read_data", 32'(rsp_tdata[27:20]), 32'(want.data));
               if (rsp_tdata[31:28] !== 4'd0)
                  report_mismatch("padding", 32'(rsp_tdata[31:28]), '0);
            end
            rsp_index = rsp_index + 1;
         end
         if (req_tvalid && req_tready) begin
            parse_beat(req_tuser, req_tdata[7:0], req_tdata[23:8], want);
            awaited_rsp_q.push_back(want);
         end
      end
      pending_count = awaited_rsp_q.size();
   end

endmodule

// File: sim/hex_record_image_loader_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the hex record image loader: clock, reset, request beats
// built from HEX records and response back-pressure. Depends on hrl_pkg,
// hex_record_image_loader_top and hex_record_image_loader_checker.
module hex_record_image_loader_top_tb;
   import hrl_pkg::*;

   localparam int RANDOM_BEATS = 120;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 200;

   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_NINE    = "9";
   localparam logic [7:0] CHAR_LOWER_A = "a";
   localparam logic [7:0] CHAR_LOWER_F = "f";
   localparam logic [7:0] CHAR_LOWER_G = "g";
   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_F = "F";
   localparam logic [7:0] CHAR_UPPER_G = "G";

   typedef enum int {
      FLT_NONE  = 0,
      FLT_SUM   = 1,
      FLT_CHAR  = 2,
      FLT_ODD   = 3,
      FLT_COLON = 4
   } record_fault_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   int          error_count;
   int          pending_count;
   logic [16:0] written_span;

   int          cycle_count;
   int          burst_left;
   int          beat_tally;
   bit          tally_on;
   bit          fast_mode;
   int          hold_asked;

   hex_record_image_loader_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hex_record_image_loader_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .written_span  (written_span)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hex_record_image_loader_top_tb: FAIL");
         $finish;
      end
   end

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] base;
      if (n < 4'd10) return CHAR_ZERO + 8'(n);
      base = ($urandom_range(0, 1) != 0) ? CHAR_LOWER_A : CHAR_UPPER_A;
      return base + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] filler_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == CHAR_LF || c == CHAR_CR || c == CHAR_PLUS || c == CHAR_COLON);
      return c;
   endfunction

   function automatic logic [7:0] bad_hex_char();
      logic [7:0] c;
      if ($urandom_range(0, 1) != 0) begin
         c = ($urandom_range(0, 1) != 0) ? CHAR_LOWER_G : CHAR_UPPER_G;
         return c + 8'($urandom_range(0, 19));
      end
      do begin
         c = 8'($urandom_range(1, 255));
      end while (is_hex(c) || c == CHAR_LF || c == CHAR_CR || c == CHAR_PLUS);
      return c;
   endfunction

   task automatic send_beat(input logic func, input logic [7:0] ch,
                            input logic [15:0] addr);
      int gap;
      if (!fast_mode) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
            end
         end
         burst_left = burst_left - 1;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {addr, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (tally_on) beat_tally = beat_tally + 1;
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_beat(1'b0, ch, 16'($urandom_range(0, 65535)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_read();
      if (written_span != '0) begin
         send_beat(1'b1, 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, int'(written_span) - 1)));
      end
   endtask

   task automatic send_line_end();
      case ($urandom_range(0, 3))
         0: send_char(CHAR_LF);
         1: send_char(CHAR_CR);
         2: send_char(CHAR_NUL);
         default: begin
            send_char(CHAR_CR);
            send_char(CHAR_LF);
         end
      endcase
   endtask

   task automatic send_header();
      send_char(CHAR_PLUS);
      tally_on = 1'b0;
      repeat ($urandom_range(0, 8)) send_char(filler_char());
      send_line_end();
      tally_on = 1'b1;
   endtask

   task automatic send_record(input logic [7:0] cnt, input int plen,
                              input logic [7:0] kind, input record_fault_type fault,
                              input bit junk_tail);
      logic [7:0] body[$];
      logic [7:0] text[$];
      logic [7:0] sum;
      int         lead;
      int         pos;
      body.push_back(cnt);
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(kind);
      repeat (plen) body.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      foreach (body[i]) sum = sum + body[i];
      sum = 8'd0 - sum;
      if (fault == FLT_SUM) sum = sum + 8'($urandom_range(1, 255));
      body.push_back(sum);
      lead = $urandom_range(0, 2);
      repeat (lead) text.push_back(filler_char());
      text.push_back(CHAR_COLON);
      foreach (body[i]) begin
         text.push_back(hex_char(body[i][7:4]));
         text.push_back(hex_char(body[i][3:0]));
      end
      if (fault == FLT_ODD) void'(text.pop_back());
      if (fault == FLT_CHAR || fault == FLT_COLON) begin
         pos = $urandom_range(lead + 1, text.size() - 1);
         text[pos] = (fault == FLT_COLON) ? CHAR_COLON : bad_hex_char();
      end
      if (junk_tail) repeat ($urandom_range(1, 6)) text.push_back(filler_char());
      foreach (text[i]) begin
         if (!fast_mode && $urandom_range(0, 24) == 0) send_read();
         send_char(text[i]);
      end
      send_line_end();
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (2) @(posedge clock);
   endtask

   // The receiver alternates runs of ready and stall, stays ready in fast mode, and honors long holds.
   initial begin : receiver
      int   hold_left;
      int   run_left;
      int   hold_done;
      logic level;
      hold_left = 0;
      run_left  = 0;
      hold_done = 0;
      level     = 1'b1;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else if (fast_mode) begin
            rsp_tready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               level = ~level;
               if (level) begin
                  run_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
               end else begin
                  run_left = $urandom_range(1, 4);
               end
            end
            run_left = run_left - 1;
            rsp_tready <= level;
         end
      end
   end

   initial begin : stimulus
      int               n;
      int               roll;
      int               plen;
      logic [7:0]       cnt;
      logic [7:0]       kind;
      record_fault_type fault;
      bit               drained_once;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= 1'b0;
      req_tdata   <= '0;
      burst_left  = 0;
      beat_tally  = 0;
      tally_on    = 1'b0;
      fast_mode   = 1'b0;
      hold_asked  = 0;
      drained_once = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Records parse before any restart, then image reads and an empty line.
      send_record(8'd3, 3, KIND_DATA, FLT_NONE, 1'b0);
      repeat (3) send_read();
      send_char(CHAR_LF);
      send_header();
      send_record(8'd2, 2, KIND_DATA, FLT_NONE, 1'b0);
      send_record(8'd0, 0, KIND_DATA, FLT_NONE, 1'b0);
      send_record(8'd1, 1, 8'h03, FLT_NONE, 1'b0);
      send_record(8'd0, 0, KIND_EOF, FLT_NONE, 1'b0);
      send_record(8'd2, 2, KIND_EXTLIN, FLT_NONE, 1'b0);
      send_text(":00000001FF");
      send_char(CHAR_NUL);

      // Each kind of bad line, with the error repeating on later line ends.
      send_header();
      send_text(":1G");
      send_char(CHAR_LF);
      send_char(CHAR_LF);
      send_header();
      send_record(8'd2, 2, KIND_DATA, FLT_SUM, 1'b0);
      send_record(8'd1, 1, KIND_DATA, FLT_NONE, 1'b0);
      send_header();
      send_record(8'd2, 2, KIND_DATA, FLT_ODD, 1'b0);
      send_header();
      send_text("no record here");
      send_char(CHAR_CR);
      send_header();
      send_char(CHAR_COLON);
      send_char(CHAR_LF);
      send_header();
      send_text(":01FF");
      send_char(CHAR_LF);
      send_header();
      send_record(8'd3, 1, KIND_DATA, FLT_NONE, 1'b0);
      send_header();
      send_record(8'd4, 4, KIND_DATA, FLT_COLON, 1'b0);
      send_header();
      send_record(8'd4, 4, KIND_DATA, FLT_CHAR, 1'b0);

      // A record at the decode limit with ignored characters and a bad checksum;
      // the sticky error keeps counting until the line length limit is passed.
      send_header();
      send_record(8'd255, 256, KIND_DATA, FLT_SUM, 1'b1);
      fast_mode = 1'b1;
      repeat (17) begin
         repeat (30) send_char("q");
         send_char(CHAR_CR);
      end
      fast_mode = 1'b0;
      send_header();
      drain();

      // Random sessions of mostly well-formed records, with faults and noise.
      tally_on = 1'b1;
      beat_tally = 0;
      hold_asked = hold_asked + 1;
      while (beat_tally < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) != 0) send_header();
         n = $urandom_range(1, 6);
         repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) kind = KIND_DATA;
            else if (roll < 80) kind = KIND_EXTLIN;
            else if (roll < 88) kind = KIND_EOF;
            else kind = 8'($urandom_range(0, 255));
            cnt = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(17, 255))
                                                : 8'($urandom_range(0, 16));
            plen = cnt;
            roll = $urandom_range(0, 99);
            if (roll < 8) plen = cnt + $urandom_range(1, 3);
            else if (roll < 12 && cnt != 0) plen = $urandom_range(0, cnt - 1);
            if (plen > 256) plen = 256;
            fault = FLT_NONE;
            if ($urandom_range(0, 99) < 10) fault = record_fault_type'($urandom_range(1, 4));
            send_record(cnt, plen, kind, fault, plen == 256);
         end
         if ($urandom_range(0, 1) != 0) send_record(8'd0, 0, KIND_EOF, FLT_NONE, 1'b0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 5) == 0) send_char(CHAR_LF);
         if (!drained_once && beat_tally > RANDOM_BEATS / 2) begin
            drain();
            drained_once = 1'b1;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("hex_record_image_loader_top_tb: PASS");
      end else begin
         $display("hex_record_image_loader_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/hrl_pkg.sv
rtl/core/hrl_front.sv
rtl/core/hrl_queue.sv
rtl/core/hrl_back.sv
rtl/core/hex_record_image_loader_top.sv
sim/hex_record_image_loader_checker.sv
sim/hex_record_image_loader_top_tb.sv
